[hdl/nert_pkg.sv]
// Shared types and constants for the north/east to radial/transverse rotator.
// Used by every module of the block; the channel interfaces do not depend on it.
package nert_pkg;

  localparam int FRAC_BITS = 30;
  localparam int CDEG_W    = 16;
  localparam int ANG_W     = 13;
  localparam int X_W       = 30;
  localparam int T_W       = 31;
  localparam int COEF_W    = 32;
  localparam int MUL_W     = 31;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int DEN_W     = 15;
  localparam int DIVN_W    = 30;
  localparam int MAG_W     = 31;
  localparam int SH_W      = 6;
  localparam int RPROD_W   = DIVN_W + MAG_W;
  localparam int RQ_W      = 28;
  localparam int ACC_W     = ANG_W + RQ_W;
  localparam int NUM_W     = ACC_W + 1;
  localparam int Q40_SHIFT = 10;

  localparam logic [CDEG_W:0] FULL_CIRCLE = 17'd36000;
  localparam logic [CDEG_W:0] HALF_CIRCLE = 17'd18000;
  localparam logic [CDEG_W:0] QUARTER     = 17'd9000;
  localparam logic [CDEG_W:0] THREE_QTR   = 17'd27000;
  localparam logic [CDEG_W:0] OCTANT      = 17'd4500;

  // reciprocal for an exact floor(n / d), n below 2^DIVN_W:
  // q = (n * ceil(2^(DIVN_W + l) / d)) >> (DIVN_W + l), l = clog2(d)
  function automatic logic [MAG_W-1:0] recip_mag(input int unsigned d);
    longint unsigned p;
    p = 64'd1 << (DIVN_W + $clog2(d));
    return MAG_W'((p + 64'(d) - 64'd1) / 64'(d));
  endfunction

  function automatic logic [SH_W-1:0] recip_sh(input int unsigned d);
    return SH_W'(DIVN_W + $clog2(d));
  endfunction

  // a * pi / 18000 (a in hundredths of a degree) split as a * Q + floor(a * R / 18000)
  localparam logic [41:0]          PI_Q40     = 42'h3243F6A8886;
  localparam logic [41:0]          RAD_Q_FULL = PI_Q40 / 42'(HALF_CIRCLE);
  localparam logic [41:0]          RAD_R_FULL = PI_Q40 % 42'(HALF_CIRCLE);
  localparam logic [RQ_W-1:0]      RAD_Q      = RAD_Q_FULL[RQ_W-1:0];
  localparam logic [DEN_W-1:0]     RAD_R      = RAD_R_FULL[DEN_W-1:0];
  localparam logic [MAG_W-1:0]     RAD_MAG    = recip_mag(32'(HALF_CIRCLE));
  localparam logic [SH_W-1:0]      RAD_SH     = recip_sh(32'(HALF_CIRCLE));
  localparam logic [NUM_W-1:0]     RAD_RND    = NUM_W'(1) << (Q40_SHIFT - 1);

  localparam logic [T_W-1:0] ONE_Q30 = T_W'(1) << FRAC_BITS;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef enum logic [3:0] {
    TRG_IDLE,
    TRG_RANGE,
    TRG_PHI,
    TRG_PLO,
    TRG_RSTART,
    TRG_RWAIT,
    TRG_SQR,
    TRG_X2,
    TRG_HMUL,
    TRG_HSTART,
    TRG_HWAIT,
    TRG_SMUL,
    TRG_FIN
  } trig_state_t;

  typedef struct packed {
    logic                     busy;
    logic signed [COEF_W-1:0] sin_q30;
    logic signed [COEF_W-1:0] cos_q30;
  } coef_t;

endpackage

[hdl/nert_in_if.sv]
// Input channel of the rotator: east/north sample pair and record-end flag.
// Valid/ready handshake; no package dependency.
interface nert_in_if #(parameter int SAMPLE_WIDTH = 24);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] east_sample;
  logic signed [SAMPLE_WIDTH-1:0] north_sample;
  logic                           last_sample;

  modport source (output valid, output east_sample, output north_sample,
                  output last_sample, input ready);
  modport sink   (input valid, input east_sample, input north_sample,
                  input last_sample, output ready);
endinterface

[hdl/nert_out_if.sv]
// Result channel of the rotator: radial/transverse sample pair and record-end flag.
// Valid/ready handshake; no package dependency.
interface nert_out_if #(parameter int SAMPLE_WIDTH = 24);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] radial_sample;
  logic signed [SAMPLE_WIDTH-1:0] transverse_sample;
  logic                           last_out;

  modport source (output valid, output radial_sample, output transverse_sample,
                  output last_out, input ready);
  modport sink   (input valid, input radial_sample, input transverse_sample,
                  input last_out, output ready);
endinterface

[hdl/nert_div.sv]
// Quotient by a small constant divisor through reciprocal multiplication;
// the result is registered and ready in the cycle after start. Depends on nert_pkg for the operand widths.
module nert_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [nert_pkg::DIVN_W-1:0] num,
  input  logic [nert_pkg::MAG_W-1:0]  mag,
  input  logic [nert_pkg::SH_W-1:0]   sh,
  output logic                        done,
  output logic [nert_pkg::DIVN_W-1:0] quo
);
  import nert_pkg::*;

  logic               done_r;
  logic [RPROD_W-1:0] prod_r;
  logic [SH_W-1:0]    sh_r;
  logic [RPROD_W-1:0] quo_full;

  assign quo_full = prod_r >> sh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= RPROD_W'(num) * RPROD_W'(mag);
      sh_r   <= sh;
    end
  end

  assign done = done_r;
  assign quo  = quo_full[DIVN_W-1:0];

  a_div_finish: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> done_r)
    else $error("quotient not ready one cycle after start");

  a_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !start |=> !done_r)
    else $error("quotient ready without a start");

endmodule

[hdl/nert_trig.sv]
// Back-azimuth register and sine/cosine sequencer: angle reduction, series
// evaluation with a shared multiplier and nert_div. Depends on nert_pkg.
module nert_trig #(
  parameter int ROTATION_STAGES = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [nert_pkg::CDEG_W-1:0] cfg_wdata,
  output nert_pkg::coef_t             coef
);
  import nert_pkg::*;

  localparam int K_W   = $clog2(ROTATION_STAGES + 1);
  localparam int IDX_W = $clog2(ROTATION_STAGES);

  trig_state_t state_r, state_nxt;

  logic [CDEG_W-1:0]        baz_r;
  logic [ANG_W-1:0]         a_r;
  logic [1:0]               quad_r;
  logic                     swap_r;
  logic [ACC_W-1:0]         acc_r;
  logic [X_W-1:0]           x_r;
  logic [X_W-1:0]           x2_r;
  logic [T_W-1:0]           t_r;
  logic [T_W-1:0]           cos_oct_r;
  logic [K_W-1:0]           k_r;
  logic                     sinpass_r;
  logic [PROD_W-1:0]        prod_r;
  logic signed [COEF_W-1:0] sin_r, cos_r;
  logic signed [COEF_W-1:0] sin_nxt, cos_nxt;

  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod_nxt;
  logic              div_start, div_done;
  logic [DIVN_W-1:0] div_num, div_quo;
  logic [MAG_W-1:0]  div_mag;
  logic [SH_W-1:0]   div_sh;

  // angle reduction
  logic [CDEG_W:0] m_cdeg, th0, th, r_cdeg, a_full;
  logic [1:0]      quad_nxt;
  logic            swap_nxt;

  always_comb begin
    m_cdeg = ({1'b0, baz_r} >= FULL_CIRCLE) ? {1'b0, baz_r} - FULL_CIRCLE : {1'b0, baz_r};
    th0    = m_cdeg + HALF_CIRCLE;
    th     = (th0 >= FULL_CIRCLE) ? th0 - FULL_CIRCLE : th0;
    if (th < QUARTER) begin
      quad_nxt = QUAD_0;
      r_cdeg   = th;
    end else if (th < HALF_CIRCLE) begin
      quad_nxt = QUAD_1;
      r_cdeg   = th - QUARTER;
    end else if (th < THREE_QTR) begin
      quad_nxt = QUAD_2;
      r_cdeg   = th - HALF_CIRCLE;
    end else begin
      quad_nxt = QUAD_3;
      r_cdeg   = th - THREE_QTR;
    end
    swap_nxt = (r_cdeg > OCTANT);
    a_full   = swap_nxt ? QUARTER - r_cdeg : r_cdeg;
  end

  // series divisor reciprocals, entry k-1: (2k-1)(2k) for cosine, (2k)(2k+1) for sine
  logic [MAG_W-1:0] cos_mag [ROTATION_STAGES];
  logic [MAG_W-1:0] sin_mag [ROTATION_STAGES];
  logic [SH_W-1:0]  cos_sh  [ROTATION_STAGES];
  logic [SH_W-1:0]  sin_sh  [ROTATION_STAGES];
  logic [IDX_W-1:0] k_idx;

  for (genvar g = 0; g < ROTATION_STAGES; g++) begin : g_recip
    localparam int unsigned D_COS = (2 * g + 1) * (2 * g + 2);
    localparam int unsigned D_SIN = (2 * g + 2) * (2 * g + 3);
    localparam logic [MAG_W-1:0] COS_MAG = recip_mag(D_COS);
    localparam logic [MAG_W-1:0] SIN_MAG = recip_mag(D_SIN);
    localparam logic [SH_W-1:0]  COS_SH  = recip_sh(D_COS);
    localparam logic [SH_W-1:0]  SIN_SH  = recip_sh(D_SIN);
    assign cos_mag[g] = COS_MAG;
    assign sin_mag[g] = SIN_MAG;
    assign cos_sh[g]  = COS_SH;
    assign sin_sh[g]  = SIN_SH;
  end

  assign k_idx = IDX_W'(k_r - K_W'(1));

  logic [T_W-1:0]           t_new, sin_oct;
  logic [NUM_W-1:0]         rad_round;
  logic [T_W-1:0]           s0, c0;
  logic signed [COEF_W-1:0] s0s, c0s;

  assign t_new     = ONE_Q30 - T_W'(div_quo);
  assign rad_round = NUM_W'(acc_r) + NUM_W'(div_quo) + RAD_RND;
  assign sin_oct   = prod_r[FRAC_BITS +: T_W];
  assign s0        = swap_r ? cos_oct_r : sin_oct;
  assign c0        = swap_r ? sin_oct : cos_oct_r;
  assign s0s       = COEF_W'(s0);
  assign c0s       = COEF_W'(c0);
  assign prod_nxt  = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_comb begin
    state_nxt = state_r;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_mag   = '0;
    div_sh    = '0;
    case (quad_r)
      QUAD_0: begin
        sin_nxt = s0s;
        cos_nxt = c0s;
      end
      QUAD_1: begin
        sin_nxt = c0s;
        cos_nxt = -s0s;
      end
      QUAD_2: begin
        sin_nxt = -s0s;
        cos_nxt = -c0s;
      end
      default: begin
        sin_nxt = -c0s;
        cos_nxt = s0s;
      end
    endcase
    case (state_r)
      TRG_IDLE: begin
        state_nxt = TRG_IDLE;
      end
      TRG_RANGE: begin
        state_nxt = TRG_PHI;
      end
      TRG_PHI: begin
        mul_a     = MUL_W'(a_r);
        mul_b     = MUL_W'(RAD_Q);
        state_nxt = TRG_PLO;
      end
      TRG_PLO: begin
        mul_a     = MUL_W'(a_r);
        mul_b     = MUL_W'(RAD_R);
        state_nxt = TRG_RSTART;
      end
      TRG_RSTART: begin
        div_start = 1'b1;
        div_num   = prod_r[DIVN_W-1:0];
        div_mag   = RAD_MAG;
        div_sh    = RAD_SH;
        state_nxt = TRG_RWAIT;
      end
      TRG_RWAIT: begin
        if (div_done) state_nxt = TRG_SQR;
      end
      TRG_SQR: begin
        mul_a     = MUL_W'(x_r);
        mul_b     = MUL_W'(x_r);
        state_nxt = TRG_X2;
      end
      TRG_X2: begin
        state_nxt = TRG_HMUL;
      end
      TRG_HMUL: begin
        mul_a     = MUL_W'(x2_r);
        mul_b     = MUL_W'(t_r);
        state_nxt = TRG_HSTART;
      end
      TRG_HSTART: begin
        div_start = 1'b1;
        div_num   = prod_r[FRAC_BITS +: DIVN_W];
        div_mag   = sinpass_r ? sin_mag[k_idx] : cos_mag[k_idx];
        div_sh    = sinpass_r ? sin_sh[k_idx] : cos_sh[k_idx];
        state_nxt = TRG_HWAIT;
      end
      TRG_HWAIT: begin
        if (div_done) begin
          state_nxt = (k_r == K_W'(1) && sinpass_r) ? TRG_SMUL : TRG_HMUL;
        end
      end
      TRG_SMUL: begin
        mul_a     = MUL_W'(x_r);
        mul_b     = MUL_W'(t_r);
        state_nxt = TRG_FIN;
      end
      TRG_FIN: begin
        state_nxt = TRG_IDLE;
      end
      default: begin
        state_nxt = TRG_IDLE;
      end
    endcase
    if (cfg_we) state_nxt = TRG_RANGE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TRG_IDLE;
      baz_r   <= '0;
      sin_r   <= '0;
      cos_r   <= -COEF_W'(ONE_Q30);
    end else begin
      state_r <= state_nxt;
      if (cfg_we) baz_r <= cfg_wdata;
      if (state_r == TRG_FIN) begin
        sin_r <= sin_nxt;
        cos_r <= cos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    case (state_r)
      TRG_RANGE: begin
        a_r    <= ANG_W'(a_full);
        quad_r <= quad_nxt;
        swap_r <= swap_nxt;
      end
      TRG_PLO: begin
        acc_r <= prod_r[ACC_W-1:0];
      end
      TRG_RWAIT: begin
        if (div_done) x_r <= rad_round[Q40_SHIFT +: X_W];
      end
      TRG_X2: begin
        x2_r      <= prod_r[FRAC_BITS +: X_W];
        t_r       <= ONE_Q30;
        k_r       <= K_W'(ROTATION_STAGES);
        sinpass_r <= 1'b0;
      end
      TRG_HWAIT: begin
        if (div_done) begin
          if (k_r == K_W'(1)) begin
            if (!sinpass_r) begin
              cos_oct_r <= t_new;
              t_r       <= ONE_Q30;
              k_r       <= K_W'(ROTATION_STAGES);
              sinpass_r <= 1'b1;
            end else begin
              t_r <= t_new;
            end
          end else begin
            t_r <= t_new;
            k_r <= k_r - K_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  nert_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .mag   (div_mag),
    .sh    (div_sh),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign coef.busy    = (state_r != TRG_IDLE) || cfg_we;
  assign coef.sin_q30 = sin_r;
  assign coef.cos_q30 = cos_r;

  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> state_r == TRG_RANGE)
    else $error("config write did not restart coefficient sequence");

  a_last_term: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == TRG_HWAIT && div_done && k_r == K_W'(1) && sinpass_r && !cfg_we)
    |=> state_r == TRG_SMUL)
    else $error("sine series did not end after its last term");

  a_k_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == TRG_HMUL || state_r == TRG_HSTART) |-> k_r != '0)
    else $error("series term counter underflow");

endmodule

[hdl/nert_rot.sv]
// Rotation datapath: input register, four sample-by-coefficient products,
// round/saturate into the result register. Depends on nert_pkg and the channel interfaces.
module nert_rot #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic            clk,
  input  logic            rst_n,
  input  nert_pkg::coef_t coef,
  nert_in_if.sink         in_chan,
  nert_out_if.source      out_chan
);
  import nert_pkg::*;

  localparam int SW   = SAMPLE_WIDTH;
  localparam int PW   = SW + COEF_W;
  localparam int SUMW = PW + 1;
  localparam int RW   = SUMW - FRAC_BITS;
  localparam logic signed [SUMW-1:0] RND = SUMW'(1) << (FRAC_BITS - 1);

  logic v0_r, v1_r, v2_r;
  logic en0, en1, en2, take;

  logic signed [SW-1:0]     e0_r, n0_r;
  logic                     l0_r, l1_r, l2_r;
  logic signed [COEF_W-1:0] sin_c, cos_c;
  logic signed [PW-1:0]     pes_r, pnc_r, pec_r, pns_r;
  logic signed [PW-1:0]     pes_nxt, pnc_nxt, pec_nxt, pns_nxt;
  logic signed [SUMW-1:0]   rad_sum, tr_sum;
  logic [SW-1:0]            rad_nxt, tr_nxt;
  logic [SW-1:0]            rad_r, tr_r;

  function automatic logic [SW-1:0] sat(input logic [RW-1:0] v);
    logic [SW-1:0] res;
    if ((&v[RW-1:SW-1]) || !(|v[RW-1:SW-1])) begin
      res = v[SW-1:0];
    end else if (v[RW-1]) begin
      res = {1'b1, {(SW - 1){1'b0}}};
    end else begin
      res = {1'b0, {(SW - 1){1'b1}}};
    end
    return res;
  endfunction

  assign en2  = !v2_r || out_chan.ready;
  assign en1  = !v1_r || en2;
  assign en0  = !v0_r || en1;
  assign in_chan.ready = en0 && !coef.busy;
  assign take = in_chan.valid && in_chan.ready;

  assign sin_c   = coef.sin_q30;
  assign cos_c   = coef.cos_q30;
  assign pes_nxt = e0_r * sin_c;
  assign pnc_nxt = n0_r * cos_c;
  assign pec_nxt = e0_r * cos_c;
  assign pns_nxt = n0_r * sin_c;

  assign rad_sum = SUMW'(pes_r) + SUMW'(pnc_r) + RND;
  assign tr_sum  = SUMW'(pec_r) - SUMW'(pns_r) + RND;
  assign rad_nxt = sat(rad_sum[SUMW-1:FRAC_BITS]);
  assign tr_nxt  = sat(tr_sum[SUMW-1:FRAC_BITS]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en0) v0_r <= take;
      if (en1) v1_r <= v0_r;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      e0_r <= in_chan.east_sample;
      n0_r <= in_chan.north_sample;
      l0_r <= in_chan.last_sample;
    end
    if (en1 && v0_r) begin
      pes_r <= pes_nxt;
      pnc_r <= pnc_nxt;
      pec_r <= pec_nxt;
      pns_r <= pns_nxt;
      l1_r  <= l0_r;
    end
    if (en2 && v1_r) begin
      rad_r <= rad_nxt;
      tr_r  <= tr_nxt;
      l2_r  <= l1_r;
    end
  end

  assign out_chan.valid             = v2_r;
  assign out_chan.radial_sample     = rad_r;
  assign out_chan.transverse_sample = tr_r;
  assign out_chan.last_out          = l2_r;

  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    coef.busy |-> !in_chan.ready)
    else $error("transaction accepted while coefficients are updating");

  a_stage1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !en2) |=> (v1_r && $stable(pes_r) && $stable(pns_r)))
    else $error("product stage lost or changed a stalled transaction");

endmodule

[hdl/north_east_to_radial_transverse_core.sv]
// Rotates east/north seismogram sample pairs into radial/transverse pairs by the
// angle back-azimuth + 180 degrees, rounding to nearest and saturating to
// SAMPLE_WIDTH bits; the last-sample flag travels with its pair. One transaction
// is accepted per cycle unless output back-pressure or a coefficient update
// stalls the input; it passes through an input register, a product register
// and a result register. The back-azimuth register (hundredths of a degree,
// values past 35999 wrap) is to be written through cfg_we/cfg_wdata only while
// the block is idle, which the block itself does not enforce; the write starts a
// sine/cosine sequencer built on one shared multiplier and a reciprocal-multiply
// quotient unit, and input stays stalled until the new coefficients are in
// place. After reset the coefficients for a back-azimuth of zero are ready at once.
// Depends on nert_pkg, nert_in_if, nert_out_if, nert_trig and nert_rot.
module north_east_to_radial_transverse_core #(
  parameter int SAMPLE_WIDTH    = 24,
  parameter int ROTATION_STAGES = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [nert_pkg::CDEG_W-1:0] cfg_wdata,
  nert_in_if.sink                     in_chan,
  nert_out_if.source                  out_chan
);
  import nert_pkg::*;

  coef_t coef;

  nert_trig #(
    .ROTATION_STAGES (ROTATION_STAGES)
  ) u_trig (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .coef      (coef)
  );

  nert_rot #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_rot (
    .clk      (clk),
    .rst_n    (rst_n),
    .coef     (coef),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

endmodule
